[rtl/dtvbe_pkg.sv]
// shared types, constants and lookup functions for the date/time check and bcd encoder
package dtvbe_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned BcdW    = 8;
  localparam int unsigned WdayW   = 3;
  // year offset from the base year, 0..99 when valid
  localparam int unsigned YyW     = 7;
  // weekday partial sum, at most 127 + 31 + 6 + 31
  localparam int unsigned SumW    = 8;

  localparam logic [YearW-1:0]   YearMin   = 12'd2000;
  localparam logic [YearW-1:0]   YearMax   = 12'd2099;
  localparam logic [MonthW-1:0]  MonthJan  = 4'd1;
  localparam logic [MonthW-1:0]  MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0]  MonthMar  = 4'd3;
  localparam logic [MonthW-1:0]  MonthDec  = 4'd12;
  localparam logic [HourW-1:0]   HourMax   = 5'd23;
  localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
  localparam logic [SecondW-1:0] SecondMax = 6'd59;
  localparam logic [DayW-1:0]    LeapFebDays = 5'd29;
  // 28 years shift the weekday by 35 days, so adding it keeps the sum non-negative
  localparam logic [YyW-1:0]     YearBias  = 7'd28;

  // range check results handed from the checker to the first stage
  typedef struct packed {
    logic year_ok;
    logic month_ok;
    logic time_ok;
    logic early_month;  // january or february, count against the previous year
  } chk_t;

  // days in a non-leap month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // month offset of the weekday formula
  function automatic logic [WdayW-1:0] month_shift(input logic [MonthW-1:0] m);
    logic [WdayW-1:0] r;
    case (m)
      4'd1, 4'd5:   r = 3'd0;
      4'd8:         r = 3'd1;
      4'd3, 4'd11:  r = 3'd2;
      4'd2, 4'd6:   r = 3'd3;
      4'd9, 4'd12:  r = 3'd4;
      4'd4, 4'd7:   r = 3'd5;
      4'd10:        r = 3'd6;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // two bcd digits of a value up to 99, tens by reciprocal multiply
  function automatic logic [BcdW-1:0] to_bcd(input logic [YyW-1:0] v);
    logic [13:0]    prod;
    logic [3:0]     tens;
    logic [YyW-1:0] units;
    prod  = 14'(v) * 14'd103;
    tens  = prod[13:10];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  // remainder by 7 through folding powers of 8
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] s);
    logic [4:0] x;
    logic [3:0] y;
    logic [3:0] z;
    x = 5'(s[7:6]) + 5'(s[5:3]) + 5'(s[2:0]);
    y = 4'(x[4:3]) + 4'(x[2:0]);
    z = (y >= 4'd7) ? (y - 4'd7) : y;
    return z[2:0];
  endfunction

endpackage

[rtl/dtvbe_range_chk.sv]
// field range checks on the raw date and time
module dtvbe_range_chk (
  input  logic [dtvbe_pkg::YearW-1:0]   year_i,
  input  logic [dtvbe_pkg::MonthW-1:0]  month_i,
  input  logic [dtvbe_pkg::HourW-1:0]   hour_i,
  input  logic [dtvbe_pkg::MinuteW-1:0] minute_i,
  input  logic [dtvbe_pkg::SecondW-1:0] second_i,
  output dtvbe_pkg::chk_t               chk_o
);
  import dtvbe_pkg::*;

  // year window, month window, time of day, and the year borrow for jan/feb
  always_comb begin
    chk_o.year_ok     = (year_i >= YearMin) && (year_i <= YearMax);
    chk_o.month_ok    = (month_i >= MonthJan) && (month_i <= MonthDec);
    chk_o.time_ok     = (hour_i <= HourMax) && (minute_i <= MinuteMax) &&
                        (second_i <= SecondMax);
    chk_o.early_month = (month_i < MonthMar);
  end

endmodule

[rtl/date_time_validate_bcd_encode.sv]
// top level: three-stage date/time check, weekday and bcd encoder
//
// Usage:
// - Present year, month, day, hour, minute and second on the *_in_i ports and
//   raise start_i for one cycle; the item transfers at that clock edge.
// - busy_o stays low: the pipeline takes a new item in every cycle.
// - An item taken at a clock edge moves through the stage a, b and c registers;
//   its result is marked by done_o for exactly one cycle.
// - Stages: range checks and year offset; day-of-month check, weekday sum and
//   bcd packing; remainder by 7 and masking of invalid items.
// - date_ok_o is 1 for a valid item. For an invalid one the weekday and all
//   bcd bytes read zero.
// - The receiver cannot stall: a result must be taken in the cycle it shows.
// - Reset clears all stage valid bits, so no result appears for items that
//   were in flight; data registers are not reset.
// - Throughput is one item per cycle with no gaps.
module date_time_validate_bcd_encode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dtvbe_pkg::YearW-1:0]   year_in_i,
  input  logic [dtvbe_pkg::MonthW-1:0]  month_in_i,
  input  logic [dtvbe_pkg::DayW-1:0]    day_in_i,
  input  logic [dtvbe_pkg::HourW-1:0]   hour_in_i,
  input  logic [dtvbe_pkg::MinuteW-1:0] minute_in_i,
  input  logic [dtvbe_pkg::SecondW-1:0] second_in_i,
  output logic                          done_o,
  output logic                          date_ok_o,
  output logic [dtvbe_pkg::WdayW-1:0]   weekday_out_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_second_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_minute_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_hour_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_day_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_month_o,
  output logic [dtvbe_pkg::BcdW-1:0]    bcd_year_o
);
  import dtvbe_pkg::*;

  // stage a registers
  logic               a_vld_q;
  chk_t               a_chk_q;
  logic [YyW-1:0]     a_yy_q;
  logic [YyW-1:0]     a_u_q;
  logic [MonthW-1:0]  a_month_q;
  logic [DayW-1:0]    a_day_q;
  logic [HourW-1:0]   a_hour_q;
  logic [MinuteW-1:0] a_minute_q;
  logic [SecondW-1:0] a_second_q;

  // stage b registers
  logic               b_vld_q;
  logic               b_ok_q;
  logic [SumW-1:0]    b_sum_q;
  logic [BcdW-1:0]    b_sec_q, b_min_q, b_hour_q, b_day_q, b_month_q, b_year_q;

  // stage c (output) registers
  logic               c_vld_q;
  logic               c_ok_q;
  logic [WdayW-1:0]   c_wday_q;
  logic [BcdW-1:0]    c_sec_q, c_min_q, c_hour_q, c_day_q, c_month_q, c_year_q;

  chk_t               chk;
  logic [YyW-1:0]     a_yy_d;
  logic [YyW-1:0]     a_u_d;
  logic [DayW-1:0]    max_day;
  logic               day_ok;
  logic               b_ok_d;
  logic [SumW-1:0]    b_sum_d;

  logic               accept;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  dtvbe_range_chk u_range_chk (
    .year_i   (year_in_i),
    .month_i  (month_in_i),
    .hour_i   (hour_in_i),
    .minute_i (minute_in_i),
    .second_i (second_in_i),
    .chk_o    (chk)
  );

  // year offset and the biased year used by the weekday sum
  always_comb begin
    a_yy_d = 7'(year_in_i - YearMin);
    a_u_d  = a_yy_d + YearBias - 7'(chk.early_month);
  end

  // day-of-month check and weekday partial sum
  always_comb begin
    max_day = (a_month_q == MonthFeb && a_yy_q[1:0] == 2'b00) ? LeapFebDays
                                                              : month_len(a_month_q);
    day_ok  = (a_day_q != '0) && (a_day_q <= max_day);
    b_ok_d  = a_chk_q.year_ok && a_chk_q.month_ok && a_chk_q.time_ok && day_ok;
    b_sum_d = SumW'(a_u_q) + SumW'(a_u_q[YyW-1:2]) + SumW'(month_shift(a_month_q)) +
              SumW'(a_day_q);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // stage a data
  always_ff @(posedge clk_i) begin
    a_chk_q    <= chk;
    a_yy_q     <= a_yy_d;
    a_u_q      <= a_u_d;
    a_month_q  <= month_in_i;
    a_day_q    <= day_in_i;
    a_hour_q   <= hour_in_i;
    a_minute_q <= minute_in_i;
    a_second_q <= second_in_i;
  end

  // stage b data
  always_ff @(posedge clk_i) begin
    b_ok_q    <= b_ok_d;
    b_sum_q   <= b_sum_d;
    b_sec_q   <= to_bcd(7'(a_second_q));
    b_min_q   <= to_bcd(7'(a_minute_q));
    b_hour_q  <= to_bcd(7'(a_hour_q));
    b_day_q   <= to_bcd(7'(a_day_q));
    b_month_q <= to_bcd(7'(a_month_q));
    b_year_q  <= to_bcd(a_yy_q);
  end

  // stage c data, invalid items read as zero
  always_ff @(posedge clk_i) begin
    c_ok_q    <= b_ok_q;
    c_wday_q  <= b_ok_q ? mod7(b_sum_q) : '0;
    c_sec_q   <= b_ok_q ? b_sec_q   : '0;
    c_min_q   <= b_ok_q ? b_min_q   : '0;
    c_hour_q  <= b_ok_q ? b_hour_q  : '0;
    c_day_q   <= b_ok_q ? b_day_q   : '0;
    c_month_q <= b_ok_q ? b_month_q : '0;
    c_year_q  <= b_ok_q ? b_year_q  : '0;
  end

  assign done_o        = c_vld_q;
  assign date_ok_o     = c_ok_q;
  assign weekday_out_o = c_wday_q;
  assign bcd_second_o  = c_sec_q;
  assign bcd_minute_o  = c_min_q;
  assign bcd_hour_o    = c_hour_q;
  assign bcd_day_o     = c_day_q;
  assign bcd_month_o   = c_month_q;
  assign bcd_year_o    = c_year_q;

endmodule

[rtl/dtvbe_checker.sv]
// port-level checker for the date/time encoder, with its bind
module dtvbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic                          date_ok_o,
  input logic [dtvbe_pkg::WdayW-1:0]   weekday_out_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_second_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_minute_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_hour_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_day_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_month_o,
  input logic [dtvbe_pkg::BcdW-1:0]    bcd_year_o
);
  import dtvbe_pkg::*;

  // every transfer in gives a result, marked by done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##2 done_o)
    else $error("result missing three cycles after transfer");

  // no result without a matching transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a transfer");

  // invalid results are all zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !date_ok_o) |-> (weekday_out_o == '0 && bcd_second_o == '0 &&
      bcd_minute_o == '0 && bcd_hour_o == '0 && bcd_day_o == '0 &&
      bcd_month_o == '0 && bcd_year_o == '0))
    else $error("invalid result carries data");

  // valid results have a real weekday and nonzero month and day
  a_valid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && date_ok_o) |-> (weekday_out_o != 3'd7 && bcd_month_o != '0 &&
      bcd_day_o != '0))
    else $error("valid result with impossible fields");

endmodule

bind date_time_validate_bcd_encode dtvbe_checker u_dtvbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .date_ok_o     (date_ok_o),
  .weekday_out_o (weekday_out_o),
  .bcd_second_o  (bcd_second_o),
  .bcd_minute_o  (bcd_minute_o),
  .bcd_hour_o    (bcd_hour_o),
  .bcd_day_o     (bcd_day_o),
  .bcd_month_o   (bcd_month_o),
  .bcd_year_o    (bcd_year_o)
);
